// File: hw/rtl/aes_pkg.sv
`default_nettype none
package aes_pkg;

  localparam int NumRounds = 10;
  localparam logic [0:0] CfgKeyHigh = 1'b0;
  localparam logic [0:0] CfgKeyLow  = 1'b1;

  typedef logic [127:0] blk_t;

  // forward S-box
  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits in bits 127-8i -: 8
  function automatic logic [7:0] byte_of(input blk_t s, input int i);
    return s[127 - 8 * i -: 8];
  endfunction

  // SubBytes and ShiftRows
  function automatic blk_t sub_shift(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = sbox(byte_of(s, 4 * ((c + r) % 4) + r));
      end
    end
    return t;
  endfunction

  function automatic blk_t mix_cols(input blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_of(s, 4 * c);
      a1 = byte_of(s, 4 * c + 1);
      a2 = byte_of(s, 4 * c + 2);
      a3 = byte_of(s, 4 * c + 3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // one step of the key schedule
  function automatic blk_t next_key(input blk_t k, input logic [7:0] rc);
    logic [31:0] w, w0, w1, w2, w3;
    w = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    w0 = k[127:96] ^ w;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [7:0] rcon(input int i);
    logic [7:0] r;
    r = 8'h01;
    for (int j = 1; j < NumRounds; j++) begin
      if (j <= i) r = xtime(r);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/aes128_block_encrypt.sv
// AES-128 encryption over eleven register stages: key addition, then ten rounds.
// Throughput: one item per cycle unless stalled; each stage expands its own
// round key from the key carried with the item, so no settling time follows a
// key write.
// Stall: a held result at the output freezes every stage and stalls the input.
// Reset (rst_n low, synchronous) clears the valid bits and sets the key to zero.
`default_nettype none
module aes128_block_encrypt import aes_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [63:0] in_block_high,
  input  wire logic [63:0] in_block_low,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [63:0] out_cipher_high,
  output logic [63:0] out_cipher_low,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [63:0] cfg_data
);
  logic [127:0] key;
  logic [127:0] kp [NumRounds + 1];
  logic vld [NumRounds + 1];
  logic [127:0] st [NumRounds + 1];
  logic v0_r;
  logic [127:0] s0_r;
  logic [127:0] k0_r;
  logic en;
  logic cfg_we;

  // stall the whole line when the output is held
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;

  aes_keys u_keys (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .key(key)
  );

  // initial key addition
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  // capture the key alongside the item
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= {in_block_high, in_block_low} ^ key;
      k0_r <= key;
    end
  end

  assign vld[0] = v0_r;
  assign st[0] = s0_r;
  assign kp[0] = k0_r;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes_round u_rnd (
      .clk(clk), .rst_n(rst_n), .en(en), .last(g == NumRounds),
      .vld_in(vld[g - 1]), .st_in(st[g - 1]), .k_in(kp[g - 1]), .rc(rcon(g - 1)),
      .vld_out(vld[g]), .st_out(st[g]), .k_out(kp[g])
    );
  end

  assign out_valid = vld[NumRounds];
  assign out_cipher_high = st[NumRounds][127:64];
  assign out_cipher_low = st[NumRounds][63:0];
endmodule
`default_nettype wire

// File: hw/rtl/aes_keys.sv
`default_nettype none
module aes_keys import aes_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_valid,
  input  wire logic cfg_index,
  input  wire logic [63:0] cfg_data,
  output logic [127:0] key
);
  logic [63:0] key_high_r, key_low_r;

  // hold the cipher key; clear to zero on reset, then take writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgKeyHigh: key_high_r <= cfg_data;
        CfgKeyLow:  key_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign key = {key_high_r, key_low_r};
endmodule
`default_nettype wire

// File: hw/rtl/aes_round.sv
`default_nettype none
module aes_round import aes_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic last,
  input  wire logic vld_in,
  input  wire logic [127:0] st_in,
  input  wire logic [127:0] k_in,
  input  wire logic [7:0] rc,
  output logic vld_out,
  output logic [127:0] st_out,
  output logic [127:0] k_out
);
  logic vld_r;
  logic [127:0] st_r;
  logic [127:0] k_r;
  logic [127:0] ss;
  logic [127:0] nk;

  assign ss = sub_shift(st_in);
  // expand this round's key from the one carried with the item
  assign nk = next_key(k_in, rc);

  // advance one round while not stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= (last ? ss : mix_cols(ss)) ^ nk;
      k_r  <= nk;
    end
  end

  assign vld_out = vld_r;
  assign st_out = st_r;
  assign k_out = k_r;
endmodule
`default_nettype wire

// File: hw/rtl/aes_checker.sv
`default_nettype none
module aes_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [63:0] out_cipher_high
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cipher_high))
    else $error("result dropped under stall");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without cause");
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("stall while output empty");
endmodule

bind aes128_block_encrypt aes_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_cipher_high(out_cipher_high)
);
`default_nettype wire
